[design/rbmp_pkg.sv]
// shared constants, types and helper functions for the range/bearing predictor
// no dependencies; rbmp_angle and the top level import this package
package rbmp_pkg;

    // cordic angle unit geometry
    localparam int CORDIC_STEPS = 28;
    localparam int NORM_BITS    = 53;
    localparam int NORM_STAGES  = 6;
    localparam int CORDIC_W     = 56;
    localparam int ANG_W        = 33;
    localparam int T_W          = 34;
    localparam int ANGLE_LAT    = NORM_STAGES + CORDIC_STEPS + 4;

    // jacobian dividers: numerator shift and stage count
    localparam int RJ_SHIFT = 30;
    localparam int BJ_SHIFT = 32;
    localparam int RJ_LAT   = RJ_SHIFT + 1;
    localparam int BJ_LAT   = BJ_SHIFT + 1;

    // angle constants
    localparam logic signed [ANG_W-1:0] PI30       = 33'sd3373259426;
    localparam logic signed [T_W-1:0]   PI28_T     = 34'sd843314857;
    localparam logic signed [T_W-1:0]   TWO_PI28   = 34'sd1686629714;
    localparam logic signed [T_W-1:0]   THREE_PI28 = 34'sd2529944571;
    localparam logic signed [30:0]      BEAR_HI    = 31'sd843314857;
    localparam logic signed [30:0]      BEAR_LO    = -31'sd843314857;

    // output limits
    localparam logic [32:0] RANGE_MAX = 33'h1_FFFF_FFFF;
    localparam logic [32:0] UNIT_Q30  = 33'h0_4000_0000;
    localparam logic [32:0] NEG_LIM   = 33'h0_8000_0000;
    localparam logic [32:0] POS_LIM   = 33'h0_7FFF_FFFF;

    // sign and special-case flags of one beat
    typedef struct packed {
        logic dx_neg;
        logic dy_neg;
        logic ay_zero;
        logic deg;
    } rbmp_flags_t;

    // atan(2^-i) in q2.30, truncated
    function automatic logic [29:0] atan_entry(input logic [4:0] i);
        logic [29:0] v;
        case (i)
            5'd0:  v = 30'd843314856;
            5'd1:  v = 30'd497837829;
            5'd2:  v = 30'd263043836;
            5'd3:  v = 30'd133525158;
            5'd4:  v = 30'd67021686;
            5'd5:  v = 30'd33543515;
            5'd6:  v = 30'd16775850;
            5'd7:  v = 30'd8388437;
            5'd8:  v = 30'd4194282;
            5'd9:  v = 30'd2097149;
            5'd10: v = 30'd1048575;
            5'd11: v = 30'd524287;
            5'd12: v = 30'd262143;
            5'd13: v = 30'd131071;
            5'd14: v = 30'd65535;
            5'd15: v = 30'd32767;
            5'd16: v = 30'd16383;
            5'd17: v = 30'd8191;
            5'd18: v = 30'd4095;
            5'd19: v = 30'd2047;
            5'd20: v = 30'd1023;
            5'd21: v = 30'd511;
            5'd22: v = 30'd255;
            5'd23: v = 30'd127;
            5'd24: v = 30'd63;
            5'd25: v = 30'd31;
            5'd26: v = 30'd15;
            5'd27: v = 30'd7;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

    // signed 32-bit result from magnitude and sign, saturated
    function automatic logic [31:0] sat32(input logic neg, input logic [32:0] q);
        logic [32:0] lim;
        if (neg)
        begin
            lim = (q > NEG_LIM) ? NEG_LIM : q;
            return 32'd0 - lim[31:0];
        end
        lim = (q > POS_LIM) ? POS_LIM : q;
        return lim[31:0];
    endfunction

endpackage

[design/rbmp_delay.sv]
// plain register delay line with a shared advance enable
// no dependencies
module rbmp_delay #(
    parameter int W = 1,
    parameter int N = 1
) (
    input  logic         clk,
    input  logic         en,
    input  logic [W-1:0] d,
    output logic [W-1:0] q
);

    generate
        if (N == 0)
        begin : g_none
            assign q = d;
        end
        else
        begin : g_line
            logic [W-1:0] line_reg [0:N-1];

            // shift on advance
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    line_reg[0] <= d;
                    for (int i = 1; i < N; i++)
                    begin
                        line_reg[i] <= line_reg[i-1];
                    end
                end
            end

            assign q = line_reg[N-1];
        end
    endgenerate

endmodule

[design/rbmp_sqrt.sv]
// pipelined integer square root, one result bit per stage, floor result
// depends on nothing but its parameter; MW pipeline stages
module rbmp_sqrt #(
    parameter int MW = 33
) (
    input  logic              clk,
    input  logic              en,
    input  logic [2*MW-1:0]   s,
    output logic [MW-1:0]     r
);

    localparam int RW = MW + 2;

    logic [2*MW-1:0] sv_reg   [0:MW-1];
    logic [RW-1:0]   rem_reg  [0:MW-1];
    logic [MW-1:0]   root_reg [0:MW-1];

    genvar k;
    generate
        for (k = 0; k < MW; k++)
        begin : g_stage
            logic [2*MW-1:0] sv_cur;
            logic [RW-1:0]   rem_cur;
            logic [MW-1:0]   root_cur;
            logic [RW-1:0]   rr;
            logic [RW-1:0]   tr;
            logic            ge;

            if (k == 0)
            begin : g_first
                assign sv_cur   = s;
                assign rem_cur  = '0;
                assign root_cur = '0;
            end
            else
            begin : g_next
                assign sv_cur   = sv_reg[k-1];
                assign rem_cur  = rem_reg[k-1];
                assign root_cur = root_reg[k-1];
            end

            // bring down two radicand bits and try the next root bit
            assign rr = {rem_cur[MW-1:0], sv_cur[2*MW-1 -: 2]};
            assign tr = {root_cur, 2'b01};
            assign ge = (rr >= tr);

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    sv_reg[k]   <= sv_cur << 2;
                    rem_reg[k]  <= ge ? (rr - tr) : rr;
                    root_reg[k] <= {root_cur[MW-2:0], ge};
                end
            end
        end
    endgenerate

    assign r = root_reg[MW-1];

endmodule

[design/rbmp_div.sv]
// pipelined restoring divider: (num << SH) / den, one quotient bit per stage
// depends on nothing but its parameters; quotient < 2^(SH+1)
module rbmp_div #(
    parameter int NW = 33,
    parameter int DW = 33,
    parameter int SH = 30
) (
    input  logic          clk,
    input  logic          en,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic [SH:0]   quo
);

    localparam int QB = SH + 1;

    logic [DW-1:0] rem_reg [0:QB-1];
    logic [QB-1:0] lb_reg  [0:QB-1];
    logic [DW-1:0] den_reg [0:QB-1];
    logic [QB-1:0] q_reg   [0:QB-1];

    genvar k;
    generate
        for (k = 0; k < QB; k++)
        begin : g_stage
            logic [DW-1:0] rem_cur;
            logic [QB-1:0] lb_cur;
            logic [DW-1:0] d_cur;
            logic [QB-1:0] q_cur;
            logic [DW:0]   rr;
            logic [DW:0]   dd;
            logic [DW:0]   diff;
            logic          ge;

            if (k == 0)
            begin : g_first
                // upper numerator bits are known to lie below the divisor
                assign rem_cur = DW'(num >> 1);
                assign lb_cur  = {num[0], {SH{1'b0}}};
                assign d_cur   = den;
                assign q_cur   = '0;
            end
            else
            begin : g_next
                assign rem_cur = rem_reg[k-1];
                assign lb_cur  = lb_reg[k-1];
                assign d_cur   = den_reg[k-1];
                assign q_cur   = q_reg[k-1];
            end

            // shift in one numerator bit, subtract when it fits
            assign rr   = {rem_cur, lb_cur[QB-1]};
            assign dd   = {1'b0, d_cur};
            assign diff = rr - dd;
            assign ge   = (rr >= dd);

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k] <= ge ? diff[DW-1:0] : rr[DW-1:0];
                    lb_reg[k]  <= lb_cur << 1;
                    den_reg[k] <= d_cur;
                    q_reg[k]   <= {q_cur[QB-2:0], ge};
                end
            end
        end
    endgenerate

    assign quo = q_reg[QB-1];

endmodule

[design/rbmp_angle.sv]
// bearing unit: normalise, 28-step cordic vectoring, quadrant fix, heading wrap
// depends on rbmp_pkg and rbmp_delay; ANGLE_LAT pipeline stages
module rbmp_angle import rbmp_pkg::*; #(
    parameter int MW = 33
) (
    input  logic               clk,
    input  logic               en,
    input  logic [MW-1:0]      ax,
    input  logic [MW-1:0]      ay,
    input  rbmp_flags_t        flags,
    input  logic [30:0]        heading,
    output logic [30:0]        bearing
);

    localparam int FW = $bits(rbmp_flags_t);

    logic [NORM_BITS-1:0]       nx_reg [0:NORM_STAGES-1];
    logic [NORM_BITS-1:0]       ny_reg [0:NORM_STAGES-1];
    logic signed [CORDIC_W-1:0] x_reg  [0:CORDIC_STEPS-1];
    logic signed [CORDIC_W-1:0] y_reg  [0:CORDIC_STEPS-1];
    logic signed [ANG_W-1:0]    z_reg  [0:CORDIC_STEPS-1];

    logic [FW-1:0]              fl_vec;
    rbmp_flags_t                fl_a;
    logic [30:0]                hd_d;
    logic signed [ANG_W-1:0]    zb;
    logic signed [ANG_W-1:0]    zf_next;
    logic signed [ANG_W-1:0]    zf_reg;
    logic                       deg_reg;
    logic signed [T_W-1:0]      zr;
    logic signed [31:0]         a28_reg;
    logic signed [T_W-1:0]      t_reg;
    logic signed [T_W-1:0]      bear_next;
    logic signed [T_W-1:0]      bear_reg;

    // flags and heading ride alongside the cordic stages
    rbmp_delay #(.W(FW), .N(NORM_STAGES + CORDIC_STEPS)) u_fl_dly (
        .clk (clk),
        .en  (en),
        .d   (flags),
        .q   (fl_vec)
    );
    assign fl_a = rbmp_flags_t'(fl_vec);

    rbmp_delay #(.W(31), .N(NORM_STAGES + CORDIC_STEPS + 2)) u_hd_dly (
        .clk (clk),
        .en  (en),
        .d   (heading),
        .q   (hd_d)
    );

    // normalise: shift both magnitudes until the larger reaches bit 52
    genvar k;
    generate
        for (k = 0; k < NORM_STAGES; k++)
        begin : g_norm
            localparam int SH = 32 >> k;
            logic [NORM_BITS-1:0] cx;
            logic [NORM_BITS-1:0] cy;
            logic                 top_zero;

            if (k == 0)
            begin : g_first
                assign cx = NORM_BITS'(ax);
                assign cy = NORM_BITS'(ay);
            end
            else
            begin : g_next
                assign cx = nx_reg[k-1];
                assign cy = ny_reg[k-1];
            end

            assign top_zero = (((cx | cy) >> (NORM_BITS - SH)) == '0);

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    nx_reg[k] <= top_zero ? (cx << SH) : cx;
                    ny_reg[k] <= top_zero ? (cy << SH) : cy;
                end
            end
        end
    endgenerate

    // cordic vectoring, one micro-rotation per stage
    genvar i;
    generate
        for (i = 0; i < CORDIC_STEPS; i++)
        begin : g_cordic
            logic signed [CORDIC_W-1:0] cx;
            logic signed [CORDIC_W-1:0] cy;
            logic signed [ANG_W-1:0]    cz;
            logic signed [CORDIC_W-1:0] xs;
            logic signed [CORDIC_W-1:0] ys;
            logic signed [ANG_W-1:0]    tab;

            if (i == 0)
            begin : g_first
                assign cx = $signed(CORDIC_W'(nx_reg[NORM_STAGES-1]));
                assign cy = $signed(CORDIC_W'(ny_reg[NORM_STAGES-1]));
                assign cz = '0;
            end
            else
            begin : g_next
                assign cx = x_reg[i-1];
                assign cy = y_reg[i-1];
                assign cz = z_reg[i-1];
            end

            assign xs  = cx >>> i;
            assign ys  = cy >>> i;
            assign tab = $signed(ANG_W'(atan_entry(5'(i))));

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    if (!cy[CORDIC_W-1])
                    begin
                        x_reg[i] <= cx + ys;
                        y_reg[i] <= cy - xs;
                        z_reg[i] <= cz + tab;
                    end
                    else
                    begin
                        x_reg[i] <= cx - ys;
                        y_reg[i] <= cy + xs;
                        z_reg[i] <= cz - tab;
                    end
                end
            end
        end
    endgenerate

    // quadrant fix; a vector on the x axis gives exactly zero or pi
    always_comb
    begin
        zb = fl_a.ay_zero ? '0 : z_reg[CORDIC_STEPS-1];
        if (fl_a.dx_neg && fl_a.dy_neg)
        begin
            zf_next = zb - PI30;
        end
        else if (fl_a.dx_neg)
        begin
            zf_next = PI30 - zb;
        end
        else if (fl_a.dy_neg)
        begin
            zf_next = -zb;
        end
        else
        begin
            zf_next = zb;
        end
    end

    // round q2.30 to q3.28
    assign zr = T_W'(zf_reg) + T_W'(2);

    // fold the heading difference into one turn around zero
    always_comb
    begin
        if (t_reg < 0)
        begin
            bear_next = t_reg + PI28_T;
        end
        else if (t_reg >= TWO_PI28)
        begin
            bear_next = t_reg - THREE_PI28;
        end
        else
        begin
            bear_next = t_reg - PI28_T;
        end
    end

    // post-cordic stages
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            zf_reg   <= zf_next;
            deg_reg  <= fl_a.deg;
            a28_reg  <= deg_reg ? '0 : zr[T_W-1:2];
            t_reg    <= T_W'(a28_reg) - T_W'($signed(hd_d)) + PI28_T;
            bear_reg <= bear_next;
        end
    end

    assign bearing = bear_reg[30:0];

endmodule

[design/range_bearing_measurement_predict_core.sv]
// top level of the range/bearing measurement predictor with landmark jacobian
// depends on rbmp_pkg, rbmp_delay, rbmp_sqrt, rbmp_div and rbmp_angle
//
//  channel | direction | handshake           | beat contents
//  --------+-----------+---------------------+-------------------------------------------
//  in      | into core | in_valid / in_stall | robot pose, landmark mean, landmark tag
//  out     | from core | out_valid/out_stall | range, bearing, jacobian, tag, degenerate
//
// one beat may enter every cycle while in_stall is low; the longest path is the
// one-bit-per-stage square root in series with the 31-stage range dividers.
// reset clears only the valid bits; payload registers are left as they are.
// a stalled result freezes every stage at once, so in_stall follows out_stall
// while a result is held and nothing is dropped or repeated.
module range_bearing_measurement_predict_core import rbmp_pkg::*; #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [COORD_WIDTH-1:0] robot_x,
    input  logic signed [COORD_WIDTH-1:0] robot_y,
    input  logic signed [30:0]            robot_heading,
    input  logic signed [COORD_WIDTH-1:0] landmark_x,
    input  logic signed [COORD_WIDTH-1:0] landmark_y,
    input  logic [15:0]                   landmark_tag,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [32:0]                   expected_range,
    output logic signed [30:0]            expected_bearing,
    output logic signed [31:0]            jac_range_x,
    output logic signed [31:0]            jac_range_y,
    output logic signed [31:0]            jac_bearing_x,
    output logic signed [31:0]            jac_bearing_y,
    output logic [15:0]                   out_tag,
    output logic                          degenerate
);

    localparam int MW = COORD_WIDTH + 1;
    localparam int SW = 2 * MW;
    localparam int H  = (MW + 1) / 2;
    localparam int LW = MW - H;
    localparam int LF = MW + 35;
    localparam int XW = (MW > 33) ? MW : 33;
    localparam int FW = $bits(rbmp_flags_t);

    logic                 adv;

    logic signed [MW-1:0] dx;
    logic signed [MW-1:0] dy;
    logic [MW-1:0]        ax_reg;
    logic [MW-1:0]        ay_reg;
    rbmp_flags_t          flags_reg;
    logic [30:0]          hd_reg;
    logic [15:0]          tag_reg;
    logic [LF:1]          vld_reg;

    logic [2*LW-1:0]      axhh_reg;
    logic [LW+H-1:0]      axhl_reg;
    logic [2*H-1:0]       axll_reg;
    logic [2*LW-1:0]      ayhh_reg;
    logic [LW+H-1:0]      ayhl_reg;
    logic [2*H-1:0]       ayll_reg;
    logic [SW-1:0]        ax2_reg;
    logic [SW-1:0]        ay2_reg;
    logic [SW-1:0]        s_reg;

    logic [MW-1:0]        ax_b;
    logic [MW-1:0]        ay_b;
    logic [MW-1:0]        ax_r;
    logic [MW-1:0]        ay_r;
    logic [MW-1:0]        r;
    logic [MW-1:0]        r_d;
    logic [RJ_LAT-1:0]    qrx;
    logic [RJ_LAT-1:0]    qry;
    logic [BJ_LAT-1:0]    qbx;
    logic [BJ_LAT-1:0]    qby;
    logic [BJ_LAT-1:0]    qbx_d;
    logic [BJ_LAT-1:0]    qby_d;
    logic [30:0]          bear;
    logic [30:0]          bear_d;
    logic [FW-1:0]        fl_vec;
    rbmp_flags_t          fl_f;
    logic [15:0]          tag_d;

    logic [XW-1:0]        rng_ext;
    logic [32:0]          rng_next;
    logic [32:0]          qrx_c;
    logic [32:0]          qry_c;

    logic                 out_valid_reg;
    logic [32:0]          range_reg;
    logic [30:0]          bear_out_reg;
    logic [31:0]          jrx_reg;
    logic [31:0]          jry_reg;
    logic [31:0]          jbx_reg;
    logic [31:0]          jby_reg;
    logic [15:0]          tag_out_reg;
    logic                 deg_reg;

    // whole pipeline advances unless a finished beat is held
    assign in_stall = out_valid_reg & out_stall;
    assign adv      = ~in_stall;

    // stage 1: offsets and magnitudes
    assign dx = MW'(landmark_x) - MW'(robot_x);
    assign dy = MW'(landmark_y) - MW'(robot_y);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ax_reg            <= dx[MW-1] ? MW'(-dx) : dx;
            ay_reg            <= dy[MW-1] ? MW'(-dy) : dy;
            flags_reg.dx_neg  <= dx[MW-1];
            flags_reg.dy_neg  <= dy[MW-1];
            flags_reg.ay_zero <= (dy == '0);
            flags_reg.deg     <= (dx == '0) && (dy == '0);
            hd_reg            <= robot_heading;
            tag_reg           <= landmark_tag;
        end
    end

    // valid bits travel with the stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg       <= {vld_reg[LF-1:1], in_valid};
            out_valid_reg <= vld_reg[LF];
        end
    end

    // stages 2 to 4: squares from half-width partial products, then the sum
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            axhh_reg <= ax_reg[MW-1:H] * ax_reg[MW-1:H];
            axhl_reg <= ax_reg[MW-1:H] * ax_reg[H-1:0];
            axll_reg <= ax_reg[H-1:0] * ax_reg[H-1:0];
            ayhh_reg <= ay_reg[MW-1:H] * ay_reg[MW-1:H];
            ayhl_reg <= ay_reg[MW-1:H] * ay_reg[H-1:0];
            ayll_reg <= ay_reg[H-1:0] * ay_reg[H-1:0];
            ax2_reg  <= (SW'(axhh_reg) << (2 * H)) + (SW'(axhl_reg) << (H + 1))
                        + SW'(axll_reg);
            ay2_reg  <= (SW'(ayhh_reg) << (2 * H)) + (SW'(ayhl_reg) << (H + 1))
                        + SW'(ayll_reg);
            s_reg    <= ax2_reg + ay2_reg;
        end
    end

    // range
    rbmp_sqrt #(.MW(MW)) u_sqrt (
        .clk (clk),
        .en  (adv),
        .s   (s_reg),
        .r   (r)
    );

    // magnitudes aligned with the squared range and with the range
    rbmp_delay #(.W(MW), .N(3)) u_axb_dly (.clk(clk), .en(adv), .d(ax_reg), .q(ax_b));
    rbmp_delay #(.W(MW), .N(3)) u_ayb_dly (.clk(clk), .en(adv), .d(ay_reg), .q(ay_b));
    rbmp_delay #(.W(MW), .N(MW + 3)) u_axr_dly (.clk(clk), .en(adv), .d(ax_reg), .q(ax_r));
    rbmp_delay #(.W(MW), .N(MW + 3)) u_ayr_dly (.clk(clk), .en(adv), .d(ay_reg), .q(ay_r));

    // range jacobian row: magnitude * 2^30 / range
    rbmp_div #(.NW(MW), .DW(MW), .SH(RJ_SHIFT)) u_div_rx (
        .clk (clk),
        .en  (adv),
        .num (ax_r),
        .den (r),
        .quo (qrx)
    );

    rbmp_div #(.NW(MW), .DW(MW), .SH(RJ_SHIFT)) u_div_ry (
        .clk (clk),
        .en  (adv),
        .num (ay_r),
        .den (r),
        .quo (qry)
    );

    // bearing jacobian row: magnitude * 2^32 / squared range
    rbmp_div #(.NW(MW), .DW(SW), .SH(BJ_SHIFT)) u_div_bx (
        .clk (clk),
        .en  (adv),
        .num (ay_b),
        .den (s_reg),
        .quo (qbx)
    );

    rbmp_div #(.NW(MW), .DW(SW), .SH(BJ_SHIFT)) u_div_by (
        .clk (clk),
        .en  (adv),
        .num (ax_b),
        .den (s_reg),
        .quo (qby)
    );

    // bearing
    rbmp_angle #(.MW(MW)) u_angle (
        .clk     (clk),
        .en      (adv),
        .ax      (ax_reg),
        .ay      (ay_reg),
        .flags   (flags_reg),
        .heading (hd_reg),
        .bearing (bear)
    );

    // bring every path to the final stage
    rbmp_delay #(.W(MW), .N(RJ_LAT)) u_r_dly (.clk(clk), .en(adv), .d(r), .q(r_d));
    rbmp_delay #(.W(BJ_LAT), .N(LF - 4 - BJ_LAT)) u_qbx_dly (
        .clk(clk), .en(adv), .d(qbx), .q(qbx_d)
    );
    rbmp_delay #(.W(BJ_LAT), .N(LF - 4 - BJ_LAT)) u_qby_dly (
        .clk(clk), .en(adv), .d(qby), .q(qby_d)
    );
    rbmp_delay #(.W(31), .N(LF - 1 - ANGLE_LAT)) u_bear_dly (
        .clk(clk), .en(adv), .d(bear), .q(bear_d)
    );
    rbmp_delay #(.W(FW), .N(LF - 1)) u_fl_dly (
        .clk(clk), .en(adv), .d(flags_reg), .q(fl_vec)
    );
    rbmp_delay #(.W(16), .N(LF - 1)) u_tag_dly (
        .clk(clk), .en(adv), .d(tag_reg), .q(tag_d)
    );
    assign fl_f = rbmp_flags_t'(fl_vec);

    // range saturation and unit clamp of the range row
    assign rng_ext  = XW'(r_d);
    assign rng_next = (rng_ext > XW'(RANGE_MAX)) ? RANGE_MAX : rng_ext[32:0];
    assign qrx_c    = (33'(qrx) > UNIT_Q30) ? UNIT_Q30 : 33'(qrx);
    assign qry_c    = (33'(qry) > UNIT_Q30) ? UNIT_Q30 : 33'(qry);

    // output register
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            range_reg    <= rng_next;
            bear_out_reg <= bear_d;
            jrx_reg      <= fl_f.deg ? '0 : sat32(fl_f.dx_neg, qrx_c);
            jry_reg      <= fl_f.deg ? '0 : sat32(fl_f.dy_neg, qry_c);
            jbx_reg      <= fl_f.deg ? '0 : sat32(~fl_f.dy_neg, qbx_d);
            jby_reg      <= fl_f.deg ? '0 : sat32(fl_f.dx_neg, qby_d);
            tag_out_reg  <= tag_d;
            deg_reg      <= fl_f.deg;
        end
    end

    assign out_valid        = out_valid_reg;
    assign expected_range   = range_reg;
    assign expected_bearing = bear_out_reg;
    assign jac_range_x      = jrx_reg;
    assign jac_range_y      = jry_reg;
    assign jac_bearing_x    = jbx_reg;
    assign jac_bearing_y    = jby_reg;
    assign out_tag          = tag_out_reg;
    assign degenerate       = deg_reg;

    // range path and flag path must agree on a zero offset
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((expected_range == '0) == degenerate))
        else $error("range and degenerate flag disagree");

    // a degenerate beat carries an all-zero jacobian
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && degenerate |-> (jac_range_x == '0) && (jac_range_y == '0)
            && (jac_bearing_x == '0) && (jac_bearing_y == '0))
        else $error("jacobian not cleared on degenerate beat");

    // range row stays within plus or minus one in q1.30
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (jac_range_x <= 32'sh4000_0000) && (jac_range_x >= -32'sh4000_0000)
            && (jac_range_y <= 32'sh4000_0000) && (jac_range_y >= -32'sh4000_0000))
        else $error("range jacobian out of unit interval");

    // bearing lies in one turn
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (expected_bearing >= BEAR_LO) && (expected_bearing < BEAR_HI))
        else $error("bearing outside wrap interval");

endmodule

[dv/range_bearing_measurement_predict_core_tb.sv]
// self-checking testbench for range_bearing_measurement_predict_core
// depends on rbmp_pkg and the design sources; a directed table then random beats
`timescale 1ns / 1ps

module range_bearing_measurement_predict_core_tb;
    import rbmp_pkg::*;

    localparam longint HALF_TURN_Q30 = 64'sd3373259426;
    localparam longint HALF_TURN_Q28 = 64'sd843314857;
    localparam longint FULL_TURN_Q28 = 64'sd1686629714;
    localparam int     N_RANDOM      = 1130;

    // atan(2^-i) in q2.30, truncated
    localparam longint ROT_ANGLE [28] = '{
        843314856, 497837829, 263043836, 133525158, 67021686,
        33543515, 16775850, 8388437, 4194282, 2097149,
        1048575, 524287, 262143, 131071, 65535, 32767,
        16383, 8191, 4095, 2047, 1023, 511, 255, 127,
        63, 31, 15, 7
    };

    typedef struct {
        logic [31:0] rx, ry, lx, ly;
        logic [30:0] hd;
        logic [15:0] tag;
    } pose_pair_t;

    typedef struct {
        logic [32:0] range_q;
        logic [30:0] bearing;
        logic [31:0] jrx, jry, jbx, jby;
        logic [15:0] tag;
        logic        deg;
    } measurement_t;

    typedef struct {
        pose_pair_t   stim;
        bit           typed;
        measurement_t res;
    } table_row_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [31:0] robot_x, robot_y, landmark_x, landmark_y;
    logic [30:0] robot_heading;
    logic [15:0] landmark_tag;
    logic        out_valid;
    logic        out_stall;
    logic [32:0] expected_range;
    logic [30:0] expected_bearing;
    logic [31:0] jac_range_x, jac_range_y, jac_bearing_x, jac_bearing_y;
    logic [15:0] out_tag;
    logic        degenerate;

    measurement_t pending_measurements[$];
    int           mismatch_count = 0;
    int           result_stall_left = 0;
    bit           calm = 0;

    range_bearing_measurement_predict_core dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .robot_x(robot_x), .robot_y(robot_y), .robot_heading(robot_heading),
        .landmark_x(landmark_x), .landmark_y(landmark_y), .landmark_tag(landmark_tag),
        .out_valid(out_valid), .out_stall(out_stall),
        .expected_range(expected_range), .expected_bearing(expected_bearing),
        .jac_range_x(jac_range_x), .jac_range_y(jac_range_y),
        .jac_bearing_x(jac_bearing_x), .jac_bearing_y(jac_bearing_y),
        .out_tag(out_tag), .degenerate(degenerate)
    );

    // clock, 4 ns period
    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // signed q1.30 or q16.16 from magnitude and sign, saturated to 32 bits
    function automatic logic [31:0] clamp_q(input bit neg, input logic [127:0] q);
        logic [127:0] lim;
        if (neg)
        begin
            lim = (q > 128'h8000_0000) ? 128'h8000_0000 : q;
            return 32'd0 - lim[31:0];
        end
        lim = (q > 128'h7FFF_FFFF) ? 128'h7FFF_FFFF : q;
        return lim[31:0];
    endfunction

    // atan2 of a nonzero offset, q2.30, by vectoring rotations
    function automatic longint offset_angle(input longint dx, input longint dy);
        logic [63:0] ax, ay, m;
        longint x, y, z, xs, ys;
        ax = (dx < 0) ? -dx : dx;
        ay = (dy < 0) ? -dy : dy;
        m = (ax > ay) ? ax : ay;
        z = '0;
        if (ay != 0)
        begin
            while (m < (64'd1 << 52))
            begin
                m = m << 1;
                ax = ax << 1;
                ay = ay << 1;
            end
            x = ax;
            y = ay;
            for (int i = 0; i < 28; i++)
            begin
                xs = x >>> i;
                ys = y >>> i;
                if (y >= 0)
                begin
                    x = x + ys;
                    y = y - xs;
                    z = z + ROT_ANGLE[i];
                end
                else
                begin
                    x = x - ys;
                    y = y + xs;
                    z = z - ROT_ANGLE[i];
                end
            end
        end
        if (dx < 0)
            z = HALF_TURN_Q30 - z;
        if (dy < 0)
            z = -z;
        return z;
    endfunction

    // range, bearing and landmark jacobian for one pose/landmark pair
    function automatic measurement_t predict_measurement(input pose_pair_t p);
        measurement_t m;
        longint dx, dy, hd, a28, t;
        logic [63:0] ax, ay, r, cand;
        logic [127:0] s, q;
        dx = longint'($signed(p.lx)) - longint'($signed(p.rx));
        dy = longint'($signed(p.ly)) - longint'($signed(p.ry));
        hd = longint'($signed(p.hd));
        ax = (dx < 0) ? -dx : dx;
        ay = (dy < 0) ? -dy : dy;
        s = {64'd0, ax} * {64'd0, ax} + {64'd0, ay} * {64'd0, ay};
        r = '0;
        for (int b = 62; b >= 0; b--)
        begin
            cand = r | (64'd1 << b);
            if (s >= {64'd0, cand} * {64'd0, cand})
                r = cand;
        end
        m.range_q = (r > 64'h1_FFFF_FFFF) ? 33'h1_FFFF_FFFF : r[32:0];

        // bearing, folded into [-pi, pi)
        a28 = (r == 0 && ax == 0 && ay == 0) ? 64'sd0
            : ((offset_angle(dx, dy) + 64'sd2) >>> 2);
        t = (a28 - hd + HALF_TURN_Q28) % FULL_TURN_Q28;
        if (t < 0)
            t = t + FULL_TURN_Q28;
        t = t - HALF_TURN_Q28;
        m.bearing = t[30:0];

        if (r == 0)
        begin
            m.jrx = '0;
            m.jry = '0;
            m.jbx = '0;
            m.jby = '0;
            m.deg = 1'b1;
        end
        else
        begin
            q = ({64'd0, ax} << 30) / {64'd0, r};
            m.jrx = clamp_q(dx < 0, (q > 128'h4000_0000) ? 128'h4000_0000 : q);
            q = ({64'd0, ay} << 30) / {64'd0, r};
            m.jry = clamp_q(dy < 0, (q > 128'h4000_0000) ? 128'h4000_0000 : q);
            m.jbx = clamp_q(dy > 0, ({64'd0, ay} << 32) / s);
            m.jby = clamp_q(dx < 0, ({64'd0, ax} << 32) / s);
            m.deg = 1'b0;
        end
        m.tag = p.tag;
        return m;
    endfunction

    // present one beat and hold it until taken, then idle for a drawn gap
    task automatic send_beat(input pose_pair_t p, input measurement_t want);
        int gap;
        in_valid <= 1'b1;
        robot_x <= p.rx;
        robot_y <= p.ry;
        robot_heading <= p.hd;
        landmark_x <= p.lx;
        landmark_y <= p.ly;
        landmark_tag <= p.tag;
        pending_measurements.push_back(want);
        do
            @(posedge clk);
        while (in_stall);
        gap = calm ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // random coordinate pair component: mostly wide, sometimes near the robot
    function automatic pose_pair_t random_pair();
        pose_pair_t p;
        int shape;
        shape = $urandom_range(0, 9);
        p.rx = $urandom;
        p.ry = $urandom;
        p.lx = $urandom;
        p.ly = $urandom;
        if (shape < 3)
        begin
            p.lx = p.rx + 32'($urandom_range(0, 1 << 20)) - 32'(1 << 19);
            p.ly = p.ry + 32'($urandom_range(0, 1 << 20)) - 32'(1 << 19);
        end
        else if (shape == 3)
            p.ly = p.ry;
        else if (shape == 4)
            p.lx = p.rx;
        else if (shape == 5)
        begin
            p.lx = p.rx + 32'($urandom_range(0, 4)) - 32'd2;
            p.ly = p.ry + 32'($urandom_range(0, 4)) - 32'd2;
        end
        if ($urandom_range(0, 7) == 0)
            p.hd = 31'($urandom);
        else
            p.hd = 31'($urandom_range(0, 1686629713)) - 31'd843314857;
        p.tag = 16'($urandom);
        return p;
    endfunction

    // directed table: typed rows carry their own expected result
    table_row_t directed [] = '{
        '{'{32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 31'd0, 16'h0000},
          1'b1, '{33'd0, 31'd0, 32'd0, 32'd0, 32'd0, 32'd0, 16'h0000, 1'b1}},
        '{'{32'h0001_0000, 32'h0002_0000, 32'h0002_0000, 32'h0002_0000, 31'd0, 16'hFFFF},
          1'b1, '{33'd65536, 31'd0, 32'h4000_0000, 32'd0, 32'd0, 32'd65536,
                  16'hFFFF, 1'b0}},
        '{'{32'h0002_0000, 32'h0002_0000, 32'h0001_0000, 32'h0002_0000, 31'd0, 16'h1234},
          1'b1, '{33'd65536, -31'sd843314857, -32'sh4000_0000, 32'd0, 32'd0,
                  -32'sd65536, 16'h1234, 1'b0}},
        '{'{32'h1234_5678, 32'h8765_4321, 32'h1234_5678, 32'h8765_4321, 31'h3FFF_FFFF,
            16'h00FF}, 1'b0, '{default: '0}},
        '{'{32'h0, 32'h0, 32'h0, 32'h0, 31'h4000_0000, 16'hFF00}, 1'b0, '{default: '0}},
        '{'{32'h0, 32'h0, 32'h0, 32'h0, 31'd843314856, 16'h0001}, 1'b0, '{default: '0}},
        '{'{32'h0, 32'h0, 32'h0, 32'h0, -31'sd843314857, 16'h0002}, 1'b0, '{default: '0}},
        '{'{32'h8000_0000, 32'h0, 32'h7FFF_FFFF, 32'h0, 31'd0, 16'h0003}, 1'b0,
          '{default: '0}},
        '{'{32'h7FFF_FFFF, 32'h0, 32'h8000_0000, 32'h0, 31'd0, 16'h0004}, 1'b0,
          '{default: '0}},
        '{'{32'h0, 32'h8000_0000, 32'h0, 32'h7FFF_FFFF, 31'd0, 16'h0005}, 1'b0,
          '{default: '0}},
        '{'{32'h0, 32'h7FFF_FFFF, 32'h0, 32'h8000_0000, 31'd0, 16'h0006}, 1'b0,
          '{default: '0}},
        '{'{32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h3FFF_FFFF,
            16'h0007}, 1'b0, '{default: '0}},
        '{'{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 31'h4000_0000,
            16'h0008}, 1'b0, '{default: '0}},
        '{'{32'h0, 32'h0, 32'h0000_0001, 32'h0, 31'd0, 16'h0009}, 1'b0, '{default: '0}},
        '{'{32'h0, 32'h0, 32'h0, 32'h0000_0001, 31'd0, 16'h000A}, 1'b0, '{default: '0}},
        '{'{32'h0, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 31'd0, 16'h000B}, 1'b0,
          '{default: '0}},
        '{'{32'h0, 32'h0, 32'h0003_0000, 32'h0004_0000, 31'd843314856, 16'h000C}, 1'b0,
          '{default: '0}},
        '{'{32'h0, 32'h0, 32'hFFFD_0000, 32'hFFFC_0000, -31'sd843314857, 16'h000D}, 1'b0,
          '{default: '0}},
        '{'{32'h0, 32'h0, 32'h0, 32'hFFFF_0000, 31'h3FFF_FFFF, 16'h000E}, 1'b0,
          '{default: '0}},
        '{'{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'h0, 31'h5555_5555, 16'hAAAA}, 1'b0,
          '{default: '0}}
    };

    // stimulus
    initial
    begin
        measurement_t want;
        pose_pair_t p;
        rst_n = 1'b0;
        in_valid = 1'b0;
        robot_x = '0;
        robot_y = '0;
        robot_heading = '0;
        landmark_x = '0;
        landmark_y = '0;
        landmark_tag = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
        begin
            want = directed[i].typed ? directed[i].res : predict_measurement(directed[i].stim);
            send_beat(directed[i].stim, want);
        end

        for (int n = 0; n < N_RANDOM; n++)
        begin
            // alternate stretches with and without idling
            if (n % 150 == 0)
                calm = (n % 300 == 0);
            // drain the pipe completely partway through
            if (n == N_RANDOM / 2)
            begin
                in_valid <= 1'b0;
                while (pending_measurements.size() != 0)
                    @(posedge clk);
            end
            p = random_pair();
            send_beat(p, predict_measurement(p));
        end
        in_valid <= 1'b0;

        while (pending_measurements.size() != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
        if (mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // result side: random stall, compare each beat with the oldest prediction
    always @(posedge clk)
    begin
        measurement_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_measurements.size() == 0)
            begin
                $error("result beat with nothing expected");
                mismatch_count++;
            end
            else
            begin
                want = pending_measurements.pop_front();
                if (expected_range !== want.range_q)
                begin
                    $error("expected_range: expected %0d, got %0d", want.range_q, expected_range);
                    mismatch_count++;
                end
                if (expected_bearing !== want.bearing)
                begin
                    $error("expected_bearing: expected %0d, got %0d",
                           $signed(want.bearing), $signed(expected_bearing));
                    mismatch_count++;
                end
                if (jac_range_x !== want.jrx)
                begin
                    $error("jac_range_x: expected %0d, got %0d",
                           $signed(want.jrx), $signed(jac_range_x));
                    mismatch_count++;
                end
                if (jac_range_y !== want.jry)
                begin
                    $error("jac_range_y: expected %0d, got %0d",
                           $signed(want.jry), $signed(jac_range_y));
                    mismatch_count++;
                end
                if (jac_bearing_x !== want.jbx)
                begin
                    $error("jac_bearing_x: expected %0d, got %0d",
                           $signed(want.jbx), $signed(jac_bearing_x));
                    mismatch_count++;
                end
                if (jac_bearing_y !== want.jby)
                begin
                    $error("jac_bearing_y: expected %0d, got %0d",
                           $signed(want.jby), $signed(jac_bearing_y));
                    mismatch_count++;
                end
                if (out_tag !== want.tag)
                begin
                    $error("out_tag: expected %0d, got %0d", want.tag, out_tag);
                    mismatch_count++;
                end
                if (degenerate !== want.deg)
                begin
                    $error("degenerate: expected %0d, got %0d", want.deg, degenerate);
                    mismatch_count++;
                end
            end
            result_stall_left = calm ? 0 : $urandom_range(0, 3);
        end
        out_stall <= (result_stall_left > 0);
        if (result_stall_left > 0)
            result_stall_left--;
    end

    initial
        out_stall = 1'b0;

    // guard against a hung pipe
    initial
    begin
        #400000;
        $display("Some tests failed");
        $finish;
    end

endmodule
